// ===== src/odi_pkg.sv =====
// Shared types, constants and the arc table for the odometry integrator.
`timescale 1ns / 1ps
package odi_pkg;

  // CORDIC iterations per sine/cosine evaluation (12 to 32)
  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W        = $clog2(CORDIC_STEPS + 1);

  // Fixed scale factors
  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [31:0] HEAD_MUL   = 32'd683565276;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  // 1e9 = 2^9 * 5^9; reciprocal of 5^9 is ceil(2^84 / 5^9), exact below 2^63
  localparam int          NS_SHIFT  = 9;
  localparam logic [63:0] RECIP_5P9 = 64'd9903520314283042200;

  // Configuration register indexes
  localparam logic [1:0] CFG_LIN_GAIN = 2'd0;
  localparam logic [1:0] CFG_ANG_GAIN = 2'd1;
  localparam logic [1:0] CFG_MIN_INT  = 2'd2;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_DT_MUL,
    OP_DT_FIN,
    OP_TRIG_OLD,
    OP_POS_MUL1,
    OP_POS_MUL2,
    OP_POS_DIV,
    OP_POS_ACC,
    OP_W_MUL1,
    OP_W_DIV,
    OP_W_MUL2,
    OP_HEAD,
    OP_TRIG_HALF,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic go;
    op_t  op;
    logic axis;   // 0: x / cosine, 1: y / sine
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic drop;
    logic out_full;
  } sts_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [31:0] arc_angle(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/diff_drive_odometry_integrator_top.sv =====
// Top level of the differential-drive odometry integrator.
`timescale 1ns / 1ps
// Dead-reckoning integrator for a two-wheel drive.
// Input beats carry a timestamp and the left and right wheel speeds in rpm.
// Each beat whose time step reaches min_interval_ns advances the x/y position
// with the heading held before the step, then advances the heading, and
// yields one output beat with the pose, the heading quaternion and the speeds.
// Beats with a shorter or backward step are dropped and give no output beat.
// One beat is processed at a time: in_tready is high only while idle.
// A kept beat runs through 17 steps: seven products on the shift-add
// multiplier, three reciprocal divisions and two CORDIC passes among them,
// each step sequenced by the controller; a dropped beat ends after the
// time-step product and the drop check.
// Results sit in an output register; the next input beat is processed while
// a result waits, and the controller only holds before the final write if
// the receiver still has not taken the previous result.
// Reset (rst_n low, synchronous) restores the default gains, zeroes the pose
// and the last timestamp; the first beat therefore usually sees a saturated
// step of 2^32-1 ns. Configuration is written via cfg_we/cfg_addr/cfg_wdata,
// by the user only while idle; the block itself does not enforce this.
module diff_drive_odometry_integrator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // stamp_sec[31:0], stamp_nsec[61:32], left_rpm[77:62], right_rpm[93:78], zero fill
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, heading_angle, quat_z, quat_w, linear_speed, yaw_rate,
  // out_sec (32 bits each from bit 0), out_nsec[285:256], zero fill
  output logic [287:0] out_tdata
);
  import odi_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_load;

  assign in_load = in_tvalid && in_tready;

  odi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  odi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_load    (in_load),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a taken beat closes the input until the controller is back to idle
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_load |=> !in_tready)
    else $error("input taken twice in a row");

  // units never run while the controller is idle
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_tready)
    else $error("arithmetic unit busy while idle");

  // go is a single-cycle pulse
  a_go_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.go |=> !cmd.go)
    else $error("go held for more than one cycle");

  // quaternion components stay between -1 and +1
  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[127:96]) <= 32'sd1073741824) &&
      ($signed(out_tdata[127:96]) >= -32'sd1073741824) &&
      ($signed(out_tdata[159:128]) <= 32'sd1073741824) &&
      ($signed(out_tdata[159:128]) >= -32'sd1073741824))
    else $error("quaternion component out of range");

endmodule

// ===== src/odi_mul.sv =====
// Shift-add multiplier, 64 x 32 bits, one multiplier bit per cycle.
`timescale 1ns / 1ps
module odi_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        busy,
  output logic [95:0] prod
);
  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [95:0] mc_r;
  logic [31:0] mp_r;
  logic [95:0] acc_r;

  // one partial product added per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      mc_r   <= {32'd0, a};
      mp_r   <= b;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r  <= {mc_r[94:0], 1'b0};
      mp_r  <= {1'b0, mp_r[31:1]};
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;
endmodule

// ===== src/odi_div.sv =====
// Constant divider: floor division by 1e9 or by 5^9 through a reciprocal multiply.
`timescale 1ns / 1ps
module odi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,   // below 2^63
  input  logic        by_ns,      // 1: divide by 1e9, 0: divide by 5^9
  output logic        busy,
  output logic [63:0] quo
);
  import odi_pkg::*;

  logic        busy_r;
  logic [1:0]  cnt_r;
  logic [63:0] x_r;
  logic [65:0] acc_r;
  logic [31:0] op_x;
  logic [31:0] op_m;
  logic [63:0] pp;
  logic [65:0] acc_base;

  // one 32 x 32 partial product per cycle, 32-bit columns from the bottom up;
  // after the last column acc_r holds (x * RECIP_5P9) >> 64
  always_comb begin
    op_x = cnt_r[0] ? x_r[63:32] : x_r[31:0];
    op_m = cnt_r[1] ? RECIP_5P9[63:32] : RECIP_5P9[31:0];
    pp   = 64'(op_x) * 64'(op_m);
    case (cnt_r)
      2'd0:    acc_base = '0;
      2'd2:    acc_base = acc_r;
      default: acc_base = {32'd0, acc_r[65:32]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      x_r    <= by_ns ? (dividend >> NS_SHIFT) : dividend;
    end else if (busy_r) begin
      acc_r <= acc_base + 66'(pp);
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remaining shift of 20 completes the division by 2^84
  assign busy = busy_r;
  assign quo  = {20'd0, acc_r[63:20]};
endmodule

// ===== src/odi_cordic.sv =====
// Iterative rotation-mode CORDIC giving Q1.30 sine and cosine of a binary angle.
`timescale 1ns / 1ps
module odi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic        [31:0] angle,
  output logic               busy,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import odi_pkg::*;

  logic               busy_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               flip_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [32:0] z_r;
  logic signed [31:0] cos_r;
  logic signed [31:0] sin_r;
  logic [31:0]        turned;
  logic               flip;
  logic [31:0]        folded;
  logic [4:0]         idx;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] arc;
  logic signed [33:0] xf;
  logic signed [33:0] yf;

  function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // fold into a quarter turn either side of zero, negate results when folded
  always_comb begin
    turned = angle + 32'h4000_0000;
    flip   = turned[31];
    folded = flip ? (angle ^ 32'h8000_0000) : angle;
    idx    = 5'(cnt_r);
    dx     = y_r >>> idx;
    dy     = x_r >>> idx;
    arc    = $signed({1'b0, arc_angle(idx)});
    xf     = flip_r ? -x_r : x_r;
    yf     = flip_r ? -y_r : y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      flip_r <= flip;
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= $signed({folded[31], folded});
    end else if (busy_r) begin
      if (cnt_r == CNT_W'(CORDIC_STEPS)) begin
        cos_r  <= clamp_unit(xf);
        sin_r  <= clamp_unit(yf);
        busy_r <= 1'b0;
      end else begin
        if (!z_r[32]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - arc;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + arc;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign busy  = busy_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;
endmodule

// ===== src/odi_dp.sv =====
// Datapath: configuration, pose state, arithmetic units and the output register.
`timescale 1ns / 1ps
module odi_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_addr,
  input  logic [31:0]    cfg_wdata,
  input  logic           in_load,
  input  logic [95:0]    in_tdata,
  input  odi_pkg::cmd_t  cmd,
  output odi_pkg::sts_t  sts,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [287:0]   out_tdata
);
  import odi_pkg::*;

  // configuration
  logic [23:0] lin_gain_r;
  logic [23:0] ang_gain_r;
  logic [31:0] min_int_r;
  // current beat
  logic [31:0] sec_r;
  logic [29:0] nsec_r;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;
  // state
  logic [31:0] last_sec_r;
  logic [29:0] last_nsec_r;
  logic signed [31:0] pos_x_r;
  logic signed [31:0] pos_y_r;
  logic [31:0] head_r;
  // per-item working values
  logic [31:0] dt_r;
  logic        drop_r;
  logic signed [31:0] v_r;
  logic signed [31:0] w_r;
  // output register
  logic         out_valid_r;
  logic [287:0] out_data_r;

  logic        mul_start, mul_busy;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] mul_prod;
  logic        div_start, div_busy;
  logic        div_by_ns;
  logic [63:0] div_quo;
  logic        cor_start, cor_busy;
  logic [31:0] cor_angle;
  logic signed [31:0] cor_cos, cor_sin;

  logic signed [32:0] sec_diff;
  logic [32:0] sec_mag;
  logic signed [30:0] nsec_diff;
  logic signed [63:0] diff;
  logic [31:0] dt_sat;
  logic signed [16:0] sum_lr;
  logic signed [16:0] dif_lr;
  logic signed [41:0] lin_p;
  logic signed [41:0] ang_p;
  logic [31:0] v_mag;
  logic [31:0] w_mag;
  logic signed [31:0] c_sel;
  logic [30:0] c_mag;
  logic        step_neg;
  logic signed [36:0] step;
  logic signed [36:0] pos_sum;
  logic [31:0] dh;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // time step and speeds
  always_comb begin
    sec_diff  = $signed({1'b0, sec_r}) - $signed({1'b0, last_sec_r});
    sec_mag   = sec_diff[32] ? 33'(-sec_diff) : 33'(sec_diff);
    nsec_diff = $signed({1'b0, nsec_r}) - $signed({1'b0, last_nsec_r});
    diff      = (sec_diff[32] ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]))
              + 64'(nsec_diff);
    dt_sat    = (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
    sum_lr    = 17'(left_r) + 17'(right_r);
    dif_lr    = 17'(right_r) - 17'(left_r);
    lin_p     = $signed({1'b0, lin_gain_r}) * sum_lr;
    ang_p     = $signed({1'b0, ang_gain_r}) * dif_lr;
    v_mag     = v_r[31] ? (~v_r + 32'd1) : v_r;
    w_mag     = w_r[31] ? (~w_r + 32'd1) : w_r;
    c_sel     = cmd.axis ? cor_sin : cor_cos;
    c_mag     = c_sel[31] ? 31'(-c_sel) : c_sel[30:0];
    step_neg  = v_r[31] ^ c_sel[31];
    step      = step_neg ? -$signed({2'b00, div_quo[34:0]}) : $signed({2'b00, div_quo[34:0]});
    pos_sum   = 37'(cmd.axis ? pos_y_r : pos_x_r) + step;
    dh        = mul_prod[56:25];
  end

  // unit operand selection
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    cor_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_by_ns = 1'b1;
    cor_angle = head_r;
    case (cmd.op)
      OP_DT_MUL: begin
        mul_start = cmd.go;
        mul_a     = {31'd0, sec_mag};
        mul_b     = {2'b00, NS_PER_SEC};
      end
      OP_POS_MUL1: begin
        mul_start = cmd.go;
        mul_a     = {32'd0, v_mag};
        mul_b     = {1'b0, c_mag};
      end
      OP_POS_MUL2: begin
        mul_start = cmd.go;
        mul_a     = {32'd0, mul_prod[61:30]};
        mul_b     = dt_r;
      end
      OP_W_MUL1: begin
        mul_start = cmd.go;
        mul_a     = {32'd0, w_mag};
        mul_b     = dt_r;
      end
      OP_W_MUL2: begin
        mul_start = cmd.go;
        mul_a     = div_quo;
        mul_b     = HEAD_MUL;
      end
      OP_POS_DIV: div_start = cmd.go;
      OP_W_DIV: begin
        div_start = cmd.go;
        div_by_ns = 1'b0;
      end
      OP_TRIG_OLD: cor_start = cmd.go;
      OP_TRIG_HALF: begin
        cor_start = cmd.go;
        cor_angle = {1'b0, head_r[31:1]};
      end
      default: ;
    endcase
  end

  odi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  odi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_prod[63:0]),
    .by_ns    (div_by_ns),
    .busy     (div_busy),
    .quo      (div_quo)
  );

  odi_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .busy  (cor_busy),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_gain_r <= 24'd48674;
      ang_gain_r <= 24'd121683;
      min_int_r  <= 32'd1000000;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LIN_GAIN: lin_gain_r <= cfg_wdata[23:0];
        CFG_ANG_GAIN: ang_gain_r <= cfg_wdata[23:0];
        CFG_MIN_INT:  min_int_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_load) begin
      sec_r   <= in_tdata[31:0];
      nsec_r  <= in_tdata[61:32];
      left_r  <= $signed(in_tdata[77:62]);
      right_r <= $signed(in_tdata[93:78]);
    end
  end

  // pose state and per-item results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sec_r  <= '0;
      last_nsec_r <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      head_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.go) begin
        case (cmd.op)
          OP_DT_FIN: begin
            drop_r <= diff < $signed({32'd0, min_int_r});
            dt_r   <= dt_sat;
            v_r    <= sat34(lin_p[41:8]);
            w_r    <= sat34(ang_p[41:8]);
          end
          OP_POS_ACC: begin
            if (cmd.axis) begin
              pos_y_r <= sat37(pos_sum);
            end else begin
              pos_x_r <= sat37(pos_sum);
            end
          end
          OP_HEAD: head_r <= w_r[31] ? (head_r - dh) : (head_r + dh);
          OP_EMIT: begin
            last_sec_r  <= sec_r;
            last_nsec_r <= nsec_r;
            out_valid_r <= 1'b1;
            out_data_r  <= {2'b00, nsec_r, sec_r, w_r, v_r, cor_cos, cor_sin,
                            head_r, pos_y_r, pos_x_r};
          end
          default: ;
        endcase
      end
    end
  end

  assign sts.busy     = mul_busy | div_busy | cor_busy;
  assign sts.drop     = drop_r;
  assign sts.out_full = out_valid_r;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
endmodule

// ===== src/odi_ctrl.sv =====
// Controller: sequences the datapath operations for one beat at a time.
`timescale 1ns / 1ps
module odi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  odi_pkg::sts_t sts,
  output odi_pkg::cmd_t cmd
);
  import odi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DTMUL, S_DTFIN, S_TRIG1,
    S_XM1, S_XM2, S_XDIV, S_XACC,
    S_YM1, S_YM2, S_YDIV, S_YACC,
    S_WM1, S_WDIV, S_WM2, S_HEAD, S_TRIG2, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   issued_r;
  logic   go_r;
  op_t    op_r, op_nxt;
  logic   axis_r, axis_nxt;

  // operation and successor for each step
  always_comb begin
    op_nxt    = OP_DT_MUL;
    axis_nxt  = 1'b0;
    state_nxt = S_IDLE;
    unique case (state_r)
      S_IDLE:  state_nxt = S_DTMUL;
      S_DTMUL: begin op_nxt = OP_DT_MUL; state_nxt = S_DTFIN; end
      S_DTFIN: begin
        op_nxt    = OP_DT_FIN;
        state_nxt = sts.drop ? S_IDLE : S_TRIG1;
      end
      S_TRIG1: begin op_nxt = OP_TRIG_OLD; state_nxt = S_XM1; end
      S_XM1:   begin op_nxt = OP_POS_MUL1; state_nxt = S_XM2; end
      S_XM2:   begin op_nxt = OP_POS_MUL2; state_nxt = S_XDIV; end
      S_XDIV:  begin op_nxt = OP_POS_DIV;  state_nxt = S_XACC; end
      S_XACC:  begin op_nxt = OP_POS_ACC;  state_nxt = S_YM1; end
      S_YM1:   begin op_nxt = OP_POS_MUL1; axis_nxt = 1'b1; state_nxt = S_YM2; end
      S_YM2:   begin op_nxt = OP_POS_MUL2; axis_nxt = 1'b1; state_nxt = S_YDIV; end
      S_YDIV:  begin op_nxt = OP_POS_DIV;  axis_nxt = 1'b1; state_nxt = S_YACC; end
      S_YACC:  begin op_nxt = OP_POS_ACC;  axis_nxt = 1'b1; state_nxt = S_WM1; end
      S_WM1:   begin op_nxt = OP_W_MUL1;   state_nxt = S_WDIV; end
      S_WDIV:  begin op_nxt = OP_W_DIV;    state_nxt = S_WM2; end
      S_WM2:   begin op_nxt = OP_W_MUL2;   state_nxt = S_HEAD; end
      S_HEAD:  begin op_nxt = OP_HEAD;     state_nxt = S_TRIG2; end
      S_TRIG2: begin op_nxt = OP_TRIG_HALF; state_nxt = S_EMIT; end
      S_EMIT:  begin op_nxt = OP_EMIT;     state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  // issue one go pulse per step (the emit step first holds while the output is full), then wait for the units to settle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      go_r     <= 1'b0;
      op_r     <= OP_DT_MUL;
      axis_r   <= 1'b0;
    end else if (state_r == S_IDLE) begin
      if (in_tvalid) begin
        state_r <= state_nxt;
      end
    end else if (!issued_r) begin
      if (state_r != S_EMIT || !sts.out_full) begin
        go_r     <= 1'b1;
        op_r     <= op_nxt;
        axis_r   <= axis_nxt;
        issued_r <= 1'b1;
      end
    end else if (go_r) begin
      go_r <= 1'b0;
    end else if (!sts.busy) begin
      issued_r <= 1'b0;
      state_r  <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign cmd.go    = go_r;
  assign cmd.op    = op_r;
  assign cmd.axis  = axis_r;
endmodule
